>>> hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and codes for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

	// quaternion component slot: which output field a value lands in
	typedef enum logic [1:0] {
		SLOT_W = 2'd0,
		SLOT_X = 2'd1,
		SLOT_Y = 2'd2,
		SLOT_Z = 2'd3
	} slot_t;

endpackage

`default_nettype wire

>>> hw/rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
	parameter int RW = 30,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RW-1:0]     in_rad,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [RW/2-1:0]   out_root,
	output logic [SW-1:0]     out_side
);

	localparam int HW = RW / 2;
	localparam int MW = HW + 2;

	logic          vld_s  [0:HW];
	logic [RW-1:0] rad_s  [0:HW];
	logic [MW-1:0] rem_s  [0:HW];
	logic [HW-1:0] root_s [0:HW];
	logic [SW-1:0] side_s [0:HW];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < HW; k++) begin : g_stage
		logic [MW-1:0] trial;
		logic [MW-1:0] test;
		logic          take;

		// bring down two radicand bits, try root*4+1
		assign trial = {rem_s[k][MW-3:0], rad_s[k][RW-1:RW-2]};
		assign test  = {root_s[k], 2'b01};
		assign take  = (trial >= test);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			rem_s[k+1]  <= take ? (trial - test) : trial;
			root_s[k+1] <= {root_s[k][HW-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[HW];
	assign out_root  = root_s[HW];
	assign out_side  = side_s[HW];

endmodule

`default_nettype wire

>>> hw/rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, several lanes sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
	parameter int NW = 30,
	parameter int DW = 15,
	parameter int LN = 3,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [LN-1:0][NW-1:0]  in_num,
	input  logic [DW-1:0]          in_div,
	input  logic [SW-1:0]          in_side,
	output logic                   out_valid,
	output logic [LN-1:0][NW-1:0]  out_quo,
	output logic [DW-1:0]          out_div,
	output logic [SW-1:0]          out_side
);

	logic                  vld_s  [0:NW];
	logic [LN-1:0][NW-1:0] num_s  [0:NW];
	logic [LN-1:0][DW-1:0] rem_s  [0:NW];
	logic [DW-1:0]         div_s  [0:NW];
	logic [SW-1:0]         side_s [0:NW];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = in_num;
	assign rem_s[0]  = '0;
	assign div_s[0]  = in_div;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [LN-1:0][NW-1:0] num_n;
		logic [LN-1:0][DW-1:0] rem_n;

		// numerator shifts out at the top, quotient bits shift in at the bottom
		always_comb begin
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        take;
			for (int l = 0; l < LN; l++) begin
				trial    = {rem_s[k][l], num_s[k][l][NW-1]};
				diff     = trial - {1'b0, div_s[k]};
				take     = (trial >= {1'b0, div_s[k]});
				rem_n[l] = take ? diff[DW-1:0] : trial[DW-1:0];
				num_n[l] = {num_s[k][l][NW-2:0], take};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1]  <= num_n;
			rem_s[k+1]  <= rem_n;
			div_s[k+1]  <= div_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[NW];
	assign out_quo   = num_s[NW];
	assign out_div   = div_s[NW];
	assign out_side  = side_s[NW];

endmodule

`default_nettype wire

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to quaternion (Shoemake), fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Registers in order: stage 1, the root pipeline, stage 2, the divider pipeline and the output
// register; RW = EW+FB rounded up to even, NW = EW+FB, one bit per stage in both pipelines.
// Throughput: one transaction per cycle; busy is always low, done strobes once.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so nothing ever holds the pipeline.
`default_nettype none

module rotation_matrix_to_quaternion
	import rmq_pkg::*;
#(
	parameter int ELEM_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [ELEM_WIDTH-1:0] m00,
	input  logic signed [ELEM_WIDTH-1:0] m01,
	input  logic signed [ELEM_WIDTH-1:0] m02,
	input  logic signed [ELEM_WIDTH-1:0] m10,
	input  logic signed [ELEM_WIDTH-1:0] m11,
	input  logic signed [ELEM_WIDTH-1:0] m12,
	input  logic signed [ELEM_WIDTH-1:0] m20,
	input  logic signed [ELEM_WIDTH-1:0] m21,
	input  logic signed [ELEM_WIDTH-1:0] m22,
	output logic                         done,
	output logic signed [ELEM_WIDTH-1:0] qw,
	output logic signed [ELEM_WIDTH-1:0] qx,
	output logic signed [ELEM_WIDTH-1:0] qy,
	output logic signed [ELEM_WIDTH-1:0] qz,
	output logic                         bad_input
);

	localparam int EW   = ELEM_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int RADW = EW + 3;                 // signed radicand
	localparam int MAGW = EW + 2;                 // clamped radicand magnitude
	localparam int RW   = 2 * ((EW + FB + 1) / 2); // root input, even width
	localparam int HW   = RW / 2;                 // root width
	localparam int NW   = EW + FB;                // numerator / quotient width
	localparam int PW   = EW + 1;                 // matrix sum or difference

	localparam logic signed [RADW-1:0] ONE_R = RADW'(64'd1 << FB);
	localparam logic [NW-1:0]          MAXP  = NW'((64'd1 << (EW - 1)) - 64'd1);

	typedef struct packed {
		slot_t                hslot; // slot that takes the root
		logic [2:0]           neg;
		logic [2:0][PW-1:0]   mag;
	} front_t;

	typedef struct packed {
		slot_t      hslot;
		logic [2:0] neg;
		logic       bad;
	} back_t;

	// no backpressure anywhere
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: trace, pivot choice, radicand, the three off-diagonal terms
	// ------------------------------------------------------------------
	logic              acc;
	front_t            front_c;
	logic [RW-1:0]     rad_c;

	assign acc = start && !busy;

	always_comb begin
		logic signed [RADW-1:0] e00;
		logic signed [RADW-1:0] e11;
		logic signed [RADW-1:0] e22;
		logic signed [RADW-1:0] trace;
		logic signed [RADW-1:0] rsel;
		logic signed [PW-1:0]   p1;
		logic signed [PW-1:0]   p2;
		logic signed [PW-1:0]   p3;
		logic signed [PW-1:0]   s01;
		logic signed [PW-1:0]   s02;
		logic signed [PW-1:0]   s12;
		logic signed [PW-1:0]   d [3];
		logic signed [EW-1:0]   mii;
		logic                   i1;
		logic                   i2;
		logic [MAGW-1:0]        rmag;

		e00   = RADW'(m00);
		e11   = RADW'(m11);
		e22   = RADW'(m22);
		trace = e00 + e11 + e22;
		p1    = PW'(m21) - PW'(m12);
		p2    = PW'(m02) - PW'(m20);
		p3    = PW'(m10) - PW'(m01);
		s01   = PW'(m01) + PW'(m10);
		s02   = PW'(m02) + PW'(m20);
		s12   = PW'(m12) + PW'(m21);

		// largest diagonal, first index wins ties
		i1  = (m11 > m00);
		mii = i1 ? m11 : m00;
		i2  = (m22 > mii);

		if (trace > 0) begin
			front_c.hslot = SLOT_W;
		end else if (i2) begin
			front_c.hslot = SLOT_Z;
		end else if (i1) begin
			front_c.hslot = SLOT_Y;
		end else begin
			front_c.hslot = SLOT_X;
		end

		// lanes hold the remaining slots in ascending order
		unique case (front_c.hslot)
			SLOT_W: begin
				rsel = trace + ONE_R;
				d[0] = p1; d[1] = p2; d[2] = p3;
			end
			SLOT_X: begin
				rsel = e00 - e11 - e22 + ONE_R;
				d[0] = p1; d[1] = s01; d[2] = s02;
			end
			SLOT_Y: begin
				rsel = e11 - e22 - e00 + ONE_R;
				d[0] = p2; d[1] = s01; d[2] = s12;
			end
			SLOT_Z: begin
				rsel = e22 - e00 - e11 + ONE_R;
				d[0] = p3; d[1] = s02; d[2] = s12;
			end
			default: begin
				rsel = '0;
				d[0] = '0; d[1] = '0; d[2] = '0;
			end
		endcase

		for (int l = 0; l < 3; l++) begin
			front_c.neg[l] = d[l][PW-1];
			front_c.mag[l] = d[l][PW-1] ? PW'(-d[l]) : PW'(d[l]);
		end

		// negative radicand only from a non-orthonormal matrix: clamp to zero
		rmag  = rsel[RADW-1] ? '0 : rsel[MAGW-1:0];
		rad_c = {{(RW-MAGW){1'b0}}, rmag} << (FB - 2);
	end

	logic          v_s1;
	logic [RW-1:0] rad_s1;
	front_t        front_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1   <= rad_c;
		front_s1 <= front_c;
	end

	// ------------------------------------------------------------------
	// Root pipeline: h = floor(sqrt(R * 2^(FB-2)))
	// ------------------------------------------------------------------
	logic          sq_valid;
	logic [HW-1:0] sq_root;
	front_t        sq_side;

	rmq_sqrt #(
		.RW (RW),
		.SW ($bits(front_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_rad    (rad_s1),
		.in_side   (front_s1),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// ------------------------------------------------------------------
	// Stage 2: numerators |d| * 2^(FB-2) + h/2 for round-half-away
	// ------------------------------------------------------------------
	logic                 v_s2;
	logic [2:0][NW-1:0]   num_s2;
	logic [HW-1:0]        h_s2;
	back_t                back_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			num_s2[l] <= {1'b0, sq_side.mag[l], {(FB-2){1'b0}}}
				+ {{(NW-HW+1){1'b0}}, sq_root[HW-1:1]};
		end
		h_s2          <= sq_root;
		back_s2.hslot <= sq_side.hslot;
		back_s2.neg   <= sq_side.neg;
		back_s2.bad   <= (sq_root == '0);
	end

	// ------------------------------------------------------------------
	// Divider pipeline, three lanes against the shared root
	// ------------------------------------------------------------------
	logic               dv_valid;
	logic [2:0][NW-1:0] dv_quo;
	logic [HW-1:0]      dv_h;
	back_t              dv_side;

	rmq_div #(
		.NW (NW),
		.DW (HW),
		.LN (3),
		.SW ($bits(back_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_num    (num_s2),
		.in_div    (h_s2),
		.in_side   (back_s2),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_div   (dv_h),
		.out_side  (dv_side)
	);

	// ------------------------------------------------------------------
	// Stage 3: sign, saturate, place into slots, register the result
	// ------------------------------------------------------------------
	function automatic logic [EW-1:0] sat_q(input logic neg, input logic [NW-1:0] mag);
		logic [EW-1:0] r;
		if (!neg) begin
			r = (mag > MAXP) ? MAXP[EW-1:0] : mag[EW-1:0];
		end else if (mag > MAXP + NW'(1)) begin
			r = {1'b1, {(EW-1){1'b0}}};
		end else begin
			r = EW'(-mag[EW-1:0]);
		end
		return r;
	endfunction

	logic [EW-1:0] hv_c;
	logic [EW-1:0] l0_c;
	logic [EW-1:0] l1_c;
	logic [EW-1:0] l2_c;
	logic [EW-1:0] w_c;
	logic [EW-1:0] x_c;
	logic [EW-1:0] y_c;
	logic [EW-1:0] z_c;

	assign hv_c = sat_q(1'b0, {{(NW-HW){1'b0}}, dv_h});
	assign l0_c = sat_q(dv_side.neg[0], dv_quo[0]);
	assign l1_c = sat_q(dv_side.neg[1], dv_quo[1]);
	assign l2_c = sat_q(dv_side.neg[2], dv_quo[2]);

	always_comb begin
		unique case (dv_side.hslot)
			SLOT_W: begin
				w_c = hv_c; x_c = l0_c; y_c = l1_c; z_c = l2_c;
			end
			SLOT_X: begin
				w_c = l0_c; x_c = hv_c; y_c = l1_c; z_c = l2_c;
			end
			SLOT_Y: begin
				w_c = l0_c; x_c = l1_c; y_c = hv_c; z_c = l2_c;
			end
			SLOT_Z: begin
				w_c = l0_c; x_c = l1_c; y_c = l2_c; z_c = hv_c;
			end
			default: begin
				w_c = '0; x_c = '0; y_c = '0; z_c = '0;
			end
		endcase
	end

	logic          done_q;
	logic [EW-1:0] qw_q;
	logic [EW-1:0] qx_q;
	logic [EW-1:0] qy_q;
	logic [EW-1:0] qz_q;
	logic          bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	// zero root: quaternion forced to zero, flag raised
	always_ff @(posedge clk) begin
		qw_q  <= dv_side.bad ? '0 : w_c;
		qx_q  <= dv_side.bad ? '0 : x_c;
		qy_q  <= dv_side.bad ? '0 : y_c;
		qz_q  <= dv_side.bad ? '0 : z_c;
		bad_q <= dv_side.bad;
	end

	assign done      = done_q;
	assign qw        = qw_q;
	assign qx        = qx_q;
	assign qy        = qy_q;
	assign qz        = qz_q;
	assign bad_input = bad_q;

endmodule

`default_nettype wire
